>>> design/dwmm_pkg.sv
// ----------------------------------------------------------------------------
// dwmm_pkg
// Shared types and constants for the dual window min/max tracker.
// ----------------------------------------------------------------------------
package dwmm_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int DEF_SHORT_DEPTH   = 120;
    localparam int DEF_LONG_DEPTH    = 300;

    localparam logic signed [SAMPLE_W-1:0] MIN_INIT = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] MAX_INIT = 16'sh8000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic push;
        logic rd_en;
    } t_ring_cmd;

endpackage

>>> design/dwmm_ring.sv
// ----------------------------------------------------------------------------
// dwmm_ring
// Ring buffer memory with head/fill tracking and a min/max scan accumulator.
// ----------------------------------------------------------------------------
module dwmm_ring
    import dwmm_pkg::*;
#(
    parameter int DEPTH = DEF_SHORT_DEPTH,
    parameter int IW    = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ring_cmd                  i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [IW-1:0]              i_idx,
    output logic [IW-1:0]              o_fill,
    output logic signed [SAMPLE_W-1:0] o_min,
    output logic signed [SAMPLE_W-1:0] o_max
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    logic [AW-1:0]              r_head;
    logic [AW-1:0]              n_head;
    logic [FW-1:0]              r_fill;
    logic [FW-1:0]              n_fill;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic                       r_rd_vld;
    logic                       rd_go;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;

    assign o_fill = IW'(r_fill);
    assign rd_go  = i_cmd.rd_en && (i_idx < IW'(r_fill));
    assign o_min  = r_min;
    assign o_max  = r_max;

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_cmd.push) begin
            if (r_head == AW'(DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + AW'(1);
            end
            if (r_fill != FW'(DEPTH)) begin
                n_fill = r_fill + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_head] <= i_sample;
        end
        if (rd_go) begin
            r_rd_data <= mem[i_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_rd_vld <= rd_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_min <= MIN_INIT;
            r_max <= MAX_INIT;
        end else if (r_rd_vld) begin
            if (r_rd_data < r_min) begin
                r_min <= r_rd_data;
            end
            if (r_rd_data > r_max) begin
                r_max <= r_rd_data;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("ring fill exceeds depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < AW'(DEPTH) || DEPTH == 1)
        else $error("ring head out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> r_fill != '0)
        else $error("ring empty after push");

endmodule

>>> design/dwmm_ctrl.sv
// ----------------------------------------------------------------------------
// dwmm_ctrl
// Sequencer: push on accept, scan filled entries, hand result to output.
// ----------------------------------------------------------------------------
module dwmm_ctrl
    import dwmm_pkg::*;
#(
    parameter int IW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_free,
    input  logic [IW-1:0] i_scan_len,
    output t_ring_cmd     o_cmd,
    output logic [IW-1:0] o_idx,
    output logic          o_load
);

    t_state        r_state;
    t_state        n_state;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic          last;

    assign last  = (r_idx == i_scan_len - IW'(1));
    assign o_idx = r_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.push   = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_load       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.push = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            S_DRAIN: begin
            end
            S_DONE: begin
                o_load = i_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (i_scan_len != '0))
        else $error("scan with empty windows");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < i_scan_len))
        else $error("scan index past fill");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> (r_state == S_IDLE))
        else $error("load did not return to idle");

endmodule

>>> design/dual_window_min_max_tracker_top.sv
// ----------------------------------------------------------------------------
// dual_window_min_max_tracker_top
// Tracks min and max over a short and a long window of recent samples.
//
// Input channel (i_in_valid / o_in_ready, i_sample): one signed 16-bit
// temperature sample per transaction. Output channel (o_out_valid /
// i_out_ready): min and max over the filled entries of both windows,
// the new sample included, one result per input transaction.
// Each sample is written into both ring memories in its accept cycle, then
// the filled entries are read back one index per cycle from both memories
// in parallel, over N = max(short_fill, long_fill) indices counted after the
// new sample; N is at most the larger depth, 300 with the default depths.
// Each memory has a single read port. One item is in flight at a time: the
// next can be accepted in the cycle after the load, so a new transaction
// can start even while the previous result still waits.
// Reset empties both windows; ring contents need no clearing. A stalled
// receiver holds the result, and the sequencer waits before loading the next.
// ----------------------------------------------------------------------------
module dual_window_min_max_tracker_top
    import dwmm_pkg::*;
#(
    parameter int SHORT_DEPTH = DEF_SHORT_DEPTH,
    parameter int LONG_DEPTH  = DEF_LONG_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_short_min,
    output logic signed [SAMPLE_W-1:0] o_short_max,
    output logic signed [SAMPLE_W-1:0] o_long_min,
    output logic signed [SAMPLE_W-1:0] o_long_max
);

    localparam int MAX_DEPTH = (SHORT_DEPTH > LONG_DEPTH) ? SHORT_DEPTH : LONG_DEPTH;
    localparam int IW        = $clog2(MAX_DEPTH + 1);

    t_ring_cmd                  cmd;
    logic [IW-1:0]              idx;
    logic [IW-1:0]              s_fill;
    logic [IW-1:0]              l_fill;
    logic [IW-1:0]              scan_len;
    logic                       load;
    logic                       out_free;
    logic signed [SAMPLE_W-1:0] s_min;
    logic signed [SAMPLE_W-1:0] s_max;
    logic signed [SAMPLE_W-1:0] l_min;
    logic signed [SAMPLE_W-1:0] l_max;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_short_min;
    logic signed [SAMPLE_W-1:0] r_short_max;
    logic signed [SAMPLE_W-1:0] r_long_min;
    logic signed [SAMPLE_W-1:0] r_long_max;

    assign scan_len = (s_fill > l_fill) ? s_fill : l_fill;
    assign out_free = !r_out_valid || i_out_ready;

    dwmm_ctrl #(
        .IW (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .i_scan_len (scan_len),
        .o_cmd      (cmd),
        .o_idx      (idx),
        .o_load     (load)
    );

    dwmm_ring #(
        .DEPTH (SHORT_DEPTH),
        .IW    (IW)
    ) u_short (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_sample (i_sample),
        .i_idx    (idx),
        .o_fill   (s_fill),
        .o_min    (s_min),
        .o_max    (s_max)
    );

    dwmm_ring #(
        .DEPTH (LONG_DEPTH),
        .IW    (IW)
    ) u_long (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_sample (i_sample),
        .i_idx    (idx),
        .o_fill   (l_fill),
        .o_min    (l_min),
        .o_max    (l_max)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_short_min <= s_min;
            r_short_max <= s_max;
            r_long_min  <= l_min;
            r_long_max  <= l_max;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_short_min = r_short_min;
    assign o_short_max = r_short_max;
    assign o_long_min  = r_long_min;
    assign o_long_max  = r_long_max;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> out_free)
        else $error("result loaded over a pending transaction");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_short_min <= o_short_max) && (o_long_min <= o_long_max))
        else $error("min above max in result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_long_min <= o_short_min) && (o_long_max >= o_short_max)
                 || (SHORT_DEPTH > LONG_DEPTH))
        else $error("long window narrower than short window");

endmodule
